// ===== rtl/htt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// htt_pkg: shared types and constants of the html tag tokenizer
// scan modes, token and event codes, event bundles and byte classes
// ----------------------------------------------------------------------------
package htt_pkg;

    typedef enum logic [3:0] {
        M_DATA         = 4'd0,
        M_TEXT         = 4'd1,
        M_TAG_OPEN     = 4'd2,
        M_START_NAME   = 4'd3,
        M_END_NAME     = 4'd4,
        M_END_SKIP     = 4'd5,
        M_ATTR_WS      = 4'd6,
        M_ATTR_NAME    = 4'd7,
        M_AFTER_NAME   = 4'd8,
        M_BEFORE_VALUE = 4'd9,
        M_QUOTED       = 4'd10,
        M_UNQUOTED     = 4'd11
    } scan_mode_t;

    typedef enum logic [2:0] {
        TK_START  = 3'd0,
        TK_END    = 3'd1,
        TK_ANAME  = 3'd2,
        TK_AVALUE = 3'd3,
        TK_TEXT   = 3'd4,
        TK_EOF    = 3'd5
    } token_kind_t;

    typedef enum logic [1:0] {
        EV_OPEN  = 2'd0,
        EV_CHAR  = 2'd1,
        EV_CLOSE = 2'd2
    } event_kind_t;

    typedef enum logic [1:0] {
        REG_ATTR_LIMIT  = 2'd0,
        REG_NAME_LIMIT  = 2'd1,
        REG_VALUE_LIMIT = 2'd2,
        REG_TEXT_LIMIT  = 2'd3
    } cfg_reg_t;

    localparam int unsigned MaxEvents = 4;

    localparam logic [3:0] ATTR_LIMIT_RST  = 4'd8;
    localparam logic [4:0] NAME_LIMIT_RST  = 5'd31;
    localparam logic [6:0] VALUE_LIMIT_RST = 7'd127;
    localparam logic [7:0] TEXT_LIMIT_RST  = 8'd255;

    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef struct packed {
        logic [3:0] attr_limit;
        logic [4:0] name_limit;
        logic [6:0] value_limit;
        logic [7:0] text_limit;
    } cfg_t;

    typedef struct packed {
        token_kind_t kind;
        event_kind_t ev;
        logic [7:0]  ch;
    } event_t;

    // results caused by one input byte, oldest in slot 0
    typedef struct packed {
        logic [2:0]   cnt;
        event_t [3:0] evs;
    } bundle_t;

    typedef struct packed {
        scan_mode_t mode;
        logic [7:0] tlen;
        logic [3:0] aseen;
        logic       qsingle;
        logic       akept;
    } scan_state_t;

    typedef struct packed {
        scan_state_t st;
        bundle_t     bnd;
    } step_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == CH_DASH || c == CH_UNDER ||
               c == CH_COLON;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    // a zero limit acts as one
    function automatic logic [7:0] eff_limit(input logic [7:0] lim);
        return (lim == 8'd0) ? 8'd1 : lim;
    endfunction

    function automatic bundle_t add_ev(input bundle_t b, input token_kind_t k,
                                       input event_kind_t e, input logic [7:0] ch);
        bundle_t r;
        r = b;
        if (b.cnt < 3'(MaxEvents)) begin
            r.evs[b.cnt[1:0]] = '{kind: k, ev: e, ch: ch};
            r.cnt = b.cnt + 3'd1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/htt_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// htt_front: byte classifier and scan state machine
// takes one byte per transfer and produces the bundle of events it causes
// ----------------------------------------------------------------------------
module htt_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            accept,
    input  wire logic [7:0]      in_byte,
    input  wire logic            end_of_input,
    input  wire htt_pkg::cfg_t   cfg,
    output htt_pkg::bundle_t     push_bnd,
    output logic                 push_valid
);
    import htt_pkg::*;

    scan_state_t state_reg, state_next;
    step_t       step_res;

    function automatic step_t value_char(input step_t s, input logic [7:0] c,
                                         input logic [7:0] vlim);
        step_t r;
        r = s;
        if (r.st.akept) r.bnd = add_ev(r.bnd, TK_AVALUE, EV_CHAR, c);
        r.st.tlen = r.st.tlen + 8'd1;
        if (r.st.tlen >= vlim) begin
            if (r.st.akept) r.bnd = add_ev(r.bnd, TK_AVALUE, EV_CLOSE, CH_NUL);
            r.st.mode = M_ATTR_WS;
        end
        return r;
    endfunction

    // scan step: up to three passes when a byte is handed on to the next mode
    always_comb begin
        step_t      s;
        logic       go;
        logic [7:0] c;
        logic [7:0] nlim;
        logic [7:0] vlim;
        logic [7:0] tlim;
        token_kind_t nk;
        s.st = state_reg;
        s.bnd = '0;
        c = in_byte;
        nk = TK_START;
        nlim = eff_limit({3'd0, cfg.name_limit});
        vlim = eff_limit({1'b0, cfg.value_limit});
        tlim = eff_limit(cfg.text_limit);
        go = 1'b1;
        if (end_of_input) begin
            unique case (s.st.mode)
                M_TEXT: s.bnd = add_ev(s.bnd, TK_TEXT, EV_CLOSE, CH_NUL);
                M_TAG_OPEN: begin
                    s.bnd = add_ev(s.bnd, TK_START, EV_OPEN, CH_NUL);
                    s.bnd = add_ev(s.bnd, TK_START, EV_CLOSE, CH_NUL);
                end
                M_START_NAME: s.bnd = add_ev(s.bnd, TK_START, EV_CLOSE, CH_NUL);
                M_END_NAME: s.bnd = add_ev(s.bnd, TK_END, EV_CLOSE, CH_NUL);
                M_ATTR_NAME: begin
                    if (s.st.akept) s.bnd = add_ev(s.bnd, TK_ANAME, EV_CLOSE, CH_NUL);
                end
                M_BEFORE_VALUE: begin
                    if (s.st.akept) begin
                        s.bnd = add_ev(s.bnd, TK_AVALUE, EV_OPEN, CH_NUL);
                        s.bnd = add_ev(s.bnd, TK_AVALUE, EV_CLOSE, CH_NUL);
                    end
                end
                M_QUOTED, M_UNQUOTED: begin
                    if (s.st.akept) s.bnd = add_ev(s.bnd, TK_AVALUE, EV_CLOSE, CH_NUL);
                end
                default: ;
            endcase
            s.bnd = add_ev(s.bnd, TK_EOF, EV_OPEN, CH_NUL);
            s.st = '{mode: M_DATA, tlen: 8'd0, aseen: 4'd0, qsingle: 1'b0, akept: 1'b0};
        end else begin
            for (int p = 0; p < 3; p++) begin
                if (go) begin
                    go = 1'b0;
                    unique case (s.st.mode)
                        M_TEXT: begin
                            if (c == CH_LT) begin
                                s.bnd = add_ev(s.bnd, TK_TEXT, EV_CLOSE, CH_NUL);
                                s.st.mode = M_TAG_OPEN;
                            end else begin
                                s.bnd = add_ev(s.bnd, TK_TEXT, EV_CHAR, c);
                                s.st.tlen = s.st.tlen + 8'd1;
                                if (s.st.tlen >= tlim) begin
                                    s.bnd = add_ev(s.bnd, TK_TEXT, EV_CLOSE, CH_NUL);
                                    s.st.mode = M_DATA;
                                end
                            end
                        end
                        M_TAG_OPEN: begin
                            s.st.tlen = 8'd0;
                            if (c == CH_SLASH) begin
                                s.bnd = add_ev(s.bnd, TK_END, EV_OPEN, CH_NUL);
                                s.st.mode = M_END_NAME;
                            end else begin
                                s.bnd = add_ev(s.bnd, TK_START, EV_OPEN, CH_NUL);
                                s.st.aseen = 4'd0;
                                if (is_name_char(c)) begin
                                    s.bnd = add_ev(s.bnd, TK_START, EV_CHAR, to_lower(c));
                                    s.st.tlen = 8'd1;
                                    if (s.st.tlen >= nlim) begin
                                        s.bnd = add_ev(s.bnd, TK_START, EV_CLOSE, CH_NUL);
                                        s.st.mode = M_ATTR_WS;
                                    end else begin
                                        s.st.mode = M_START_NAME;
                                    end
                                end else begin
                                    s.bnd = add_ev(s.bnd, TK_START, EV_CLOSE, CH_NUL);
                                    s.st.mode = M_ATTR_WS;
                                    go = 1'b1;
                                end
                            end
                        end
                        M_START_NAME, M_END_NAME: begin
                            nk = (s.st.mode == M_START_NAME) ? TK_START : TK_END;
                            if (is_name_char(c)) begin
                                s.bnd = add_ev(s.bnd, nk, EV_CHAR, to_lower(c));
                                s.st.tlen = s.st.tlen + 8'd1;
                                if (s.st.tlen >= nlim) begin
                                    s.bnd = add_ev(s.bnd, nk, EV_CLOSE, CH_NUL);
                                    s.st.mode = (nk == TK_START) ? M_ATTR_WS : M_END_SKIP;
                                end
                            end else begin
                                s.bnd = add_ev(s.bnd, nk, EV_CLOSE, CH_NUL);
                                if (nk == TK_START) begin
                                    s.st.mode = M_ATTR_WS;
                                    go = 1'b1;
                                end else begin
                                    s.st.mode = (c == CH_GT) ? M_DATA : M_END_SKIP;
                                end
                            end
                        end
                        M_END_SKIP: begin
                            if (c == CH_GT) s.st.mode = M_DATA;
                        end
                        M_ATTR_WS: begin
                            if (c == CH_GT) begin
                                s.st.mode = M_DATA;
                            end else if (is_name_char(c)) begin
                                s.st.akept = (s.st.aseen < cfg.attr_limit);
                                if (s.st.akept) begin
                                    s.st.aseen = s.st.aseen + 4'd1;
                                    s.bnd = add_ev(s.bnd, TK_ANAME, EV_OPEN, CH_NUL);
                                    s.bnd = add_ev(s.bnd, TK_ANAME, EV_CHAR, to_lower(c));
                                end
                                s.st.tlen = 8'd1;
                                if (s.st.tlen >= nlim) begin
                                    if (s.st.akept)
                                        s.bnd = add_ev(s.bnd, TK_ANAME, EV_CLOSE, CH_NUL);
                                    s.st.mode = M_AFTER_NAME;
                                end else begin
                                    s.st.mode = M_ATTR_NAME;
                                end
                            end
                        end
                        M_ATTR_NAME: begin
                            if (is_name_char(c)) begin
                                if (s.st.akept)
                                    s.bnd = add_ev(s.bnd, TK_ANAME, EV_CHAR, to_lower(c));
                                s.st.tlen = s.st.tlen + 8'd1;
                                if (s.st.tlen >= nlim) begin
                                    if (s.st.akept)
                                        s.bnd = add_ev(s.bnd, TK_ANAME, EV_CLOSE, CH_NUL);
                                    s.st.mode = M_AFTER_NAME;
                                end
                            end else begin
                                if (s.st.akept)
                                    s.bnd = add_ev(s.bnd, TK_ANAME, EV_CLOSE, CH_NUL);
                                s.st.mode = M_AFTER_NAME;
                                go = 1'b1;
                            end
                        end
                        M_AFTER_NAME: begin
                            if (!is_space(c)) begin
                                if (c == CH_EQ) begin
                                    s.st.mode = M_BEFORE_VALUE;
                                end else begin
                                    s.st.mode = M_ATTR_WS;
                                    go = 1'b1;
                                end
                            end
                        end
                        M_BEFORE_VALUE: begin
                            if (!is_space(c)) begin
                                s.st.tlen = 8'd0;
                                if (s.st.akept)
                                    s.bnd = add_ev(s.bnd, TK_AVALUE, EV_OPEN, CH_NUL);
                                if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                                    s.st.qsingle = (c == CH_SQUOTE);
                                    s.st.mode = M_QUOTED;
                                end else if (c == CH_GT) begin
                                    if (s.st.akept)
                                        s.bnd = add_ev(s.bnd, TK_AVALUE, EV_CLOSE, CH_NUL);
                                    s.st.mode = M_DATA;
                                end else begin
                                    s.st.mode = M_UNQUOTED;
                                    s = value_char(s, c, vlim);
                                end
                            end
                        end
                        M_QUOTED: begin
                            if (c == (s.st.qsingle ? CH_SQUOTE : CH_DQUOTE)) begin
                                if (s.st.akept)
                                    s.bnd = add_ev(s.bnd, TK_AVALUE, EV_CLOSE, CH_NUL);
                                s.st.mode = M_ATTR_WS;
                            end else begin
                                s = value_char(s, c, vlim);
                            end
                        end
                        M_UNQUOTED: begin
                            if (is_space(c) || c == CH_GT) begin
                                if (s.st.akept)
                                    s.bnd = add_ev(s.bnd, TK_AVALUE, EV_CLOSE, CH_NUL);
                                s.st.mode = (c == CH_GT) ? M_DATA : M_ATTR_WS;
                            end else begin
                                s = value_char(s, c, vlim);
                            end
                        end
                        default: begin
                            if (c == CH_LT) begin
                                s.st.mode = M_TAG_OPEN;
                            end else begin
                                s.bnd = add_ev(s.bnd, TK_TEXT, EV_OPEN, CH_NUL);
                                s.bnd = add_ev(s.bnd, TK_TEXT, EV_CHAR, c);
                                s.st.tlen = 8'd1;
                                if (s.st.tlen >= tlim) begin
                                    s.bnd = add_ev(s.bnd, TK_TEXT, EV_CLOSE, CH_NUL);
                                    s.st.mode = M_DATA;
                                end else begin
                                    s.st.mode = M_TEXT;
                                end
                            end
                        end
                    endcase
                end
            end
        end
        step_res = s;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        if (accept) state_next = step_res.st;
    end

    // outputs
    always_comb begin
        push_bnd   = step_res.bnd;
        push_valid = accept && (step_res.bnd.cnt != 3'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{mode: M_DATA, tlen: 8'd0, aseen: 4'd0,
                           qsingle: 1'b0, akept: 1'b0};
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/htt_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// htt_queue: short queue of event bundles
// decouples the scan front from the event serializer
// ----------------------------------------------------------------------------
module htt_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire htt_pkg::bundle_t push_bnd,
    input  wire logic             pop,
    output htt_pkg::bundle_t      head_bnd,
    output logic                  full,
    output logic                  empty
);
    import htt_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    bundle_t        slot_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    // pointers wrap at the depth, which need not be a power of two
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) count_next = count_reg + CW'(1);
        else if (pop && !push) count_next = count_reg - CW'(1);
    end

    assign head_bnd = slot_reg[rd_ptr_reg];
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= push_bnd;
    end

endmodule
`default_nettype wire

// ===== rtl/htt_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// htt_back: event serializer
// sends the events of the head bundle one per transfer from an output register
// ----------------------------------------------------------------------------
module htt_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire htt_pkg::bundle_t head_bnd,
    input  wire logic             q_empty,
    output logic                  q_pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [2:0]            m_token_kind,
    output logic [1:0]            m_event_kind,
    output logic [7:0]            m_char_out,
    output logic                  m_last_of_run
);
    import htt_pkg::*;

    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    event_t     ev_reg;
    logic       last_reg;
    logic       load;
    logic       take;
    logic       last;

    always_comb begin
        load  = !valid_reg || m_ready;
        take  = load && !q_empty;
        last  = ({1'b0, idx_reg} + 3'd1) == head_bnd.cnt;
        q_pop = take && last;
        valid_next = load ? !q_empty : valid_reg;
        idx_next   = idx_reg;
        if (take) idx_next = last ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            ev_reg   <= head_bnd.evs[idx_reg];
            last_reg <= last;
        end
    end

    assign m_valid       = valid_reg;
    assign m_token_kind  = ev_reg.kind;
    assign m_event_kind  = ev_reg.ev;
    assign m_char_out    = ev_reg.ch;
    assign m_last_of_run = last_reg;

endmodule
`default_nettype wire

// ===== rtl/html_tag_tokenizer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// html_tag_tokenizer_unit: streaming html tokenizer
// byte in, open / character / close events out for text, tags and attributes
// ----------------------------------------------------------------------------
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  input   | s_valid s_ready s_in_byte s_end_of_input       | in
//  result  | m_valid m_ready m_token_kind m_event_kind      | out
//          | m_char_out m_last_of_run                       |
//  config  | cfg_we cfg_addr cfg_wdata                      | in
//
// one byte is taken per cycle while the bundle queue has room; each byte
// yields zero to four events, which the serializer sends one per cycle
// while m_ready is high, so the sustained rate is set by the output events
// first event of a byte passes the bundle queue, then the output register
// synchronous active-low reset returns to data mode and default limits
// a stalled result side fills the queue, then s_ready drops
// ----------------------------------------------------------------------------
module html_tag_tokenizer_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // input channel
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_end_of_input,
    // result channel
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_token_kind,
    output logic [1:0]      m_event_kind,
    output logic [7:0]      m_char_out,
    output logic            m_last_of_run,
    // configuration writes
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_addr,
    input  wire logic [7:0] cfg_wdata
);
    import htt_pkg::*;

    cfg_t    cfg_reg;
    logic    accept;
    bundle_t push_bnd;
    logic    push_valid;
    bundle_t head_bnd;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;

    // limit registers, to be written only while the block is idle; the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.attr_limit  <= ATTR_LIMIT_RST;
            cfg_reg.name_limit  <= NAME_LIMIT_RST;
            cfg_reg.value_limit <= VALUE_LIMIT_RST;
            cfg_reg.text_limit  <= TEXT_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_ATTR_LIMIT:  cfg_reg.attr_limit  <= cfg_wdata[3:0];
                REG_NAME_LIMIT:  cfg_reg.name_limit  <= cfg_wdata[4:0];
                REG_VALUE_LIMIT: cfg_reg.value_limit <= cfg_wdata[6:0];
                REG_TEXT_LIMIT:  cfg_reg.text_limit  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // take a byte whenever the queue can hold its bundle
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // front: scan state machine, one byte per transfer
    htt_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .in_byte      (s_in_byte),
        .end_of_input (s_end_of_input),
        .cfg          (cfg_reg),
        .push_bnd     (push_bnd),
        .push_valid   (push_valid)
    );

    // bundles of events waiting for the serializer
    htt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push_valid),
        .push_bnd (push_bnd),
        .pop      (q_pop),
        .head_bnd (head_bnd),
        .full     (q_full),
        .empty    (q_empty)
    );

    // back: one event per result transfer
    htt_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_bnd      (head_bnd),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_kind  (m_token_kind),
        .m_event_kind  (m_event_kind),
        .m_char_out    (m_char_out),
        .m_last_of_run (m_last_of_run)
    );

endmodule
`default_nettype wire

// ===== verif/token_event_checker.sv =====
// ----------------------------------------------------------------------------
// token_event_checker: event predictor and comparator for the tag tokenizer
// follows input transfers and register writes, works out the open, character
// and close events each byte causes, and compares every result transfer
// against the oldest outstanding event
// ----------------------------------------------------------------------------
module token_event_checker
    import htt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_end_of_input,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [2:0]  m_token_kind,
    input  wire logic [1:0]  m_event_kind,
    input  wire logic [7:0]  m_char_out,
    input  wire logic        m_last_of_run,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata,
    output int unsigned      mismatch_count,
    output int unsigned      events_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        token_kind_t kind;
        event_kind_t ev;
        logic [7:0]  ch;
        logic        last;
    } token_event_t;

    token_event_t expected_events[$];
    token_event_t byte_events[MaxEvents];
    int           byte_event_count;

    // scanner state
    scan_mode_t mode;
    logic [7:0] run_len;
    logic [3:0] attrs_taken;
    logic       quote_single;
    logic       attr_reported;

    // limits
    logic [3:0] attr_max;
    logic [4:0] name_max;
    logic [6:0] value_max;
    logic [7:0] text_max;

    function automatic logic blank_byte(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic name_byte(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == CH_DASH || c == CH_UNDER || c == CH_COLON;
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] floor_one(input logic [7:0] lim);
        return (lim == 8'd0) ? 8'd1 : lim;
    endfunction

    function automatic logic [7:0] name_cap();
        return floor_one({3'd0, name_max});
    endfunction

    function automatic void note_event(input token_kind_t k, input event_kind_t e,
                                       input logic [7:0] c);
        if (byte_event_count < MaxEvents) begin
            byte_events[byte_event_count] = '{kind: k, ev: e, ch: c, last: 1'b0};
            byte_event_count++;
        end
    endfunction

    function automatic void clear_scan();
        mode          = M_DATA;
        run_len       = 8'd0;
        attrs_taken   = 4'd0;
        quote_single  = 1'b0;
        attr_reported = 1'b0;
    endfunction

    function automatic void finish_document();
        case (mode)
            M_TEXT:       note_event(TK_TEXT, EV_CLOSE, 8'd0);
            M_TAG_OPEN: begin
                note_event(TK_START, EV_OPEN, 8'd0);
                note_event(TK_START, EV_CLOSE, 8'd0);
            end
            M_START_NAME: note_event(TK_START, EV_CLOSE, 8'd0);
            M_END_NAME:   note_event(TK_END, EV_CLOSE, 8'd0);
            M_ATTR_NAME: begin
                if (attr_reported) note_event(TK_ANAME, EV_CLOSE, 8'd0);
            end
            M_BEFORE_VALUE: begin
                if (attr_reported) begin
                    note_event(TK_AVALUE, EV_OPEN, 8'd0);
                    note_event(TK_AVALUE, EV_CLOSE, 8'd0);
                end
            end
            M_QUOTED, M_UNQUOTED: begin
                if (attr_reported) note_event(TK_AVALUE, EV_CLOSE, 8'd0);
            end
            default: ;
        endcase
        note_event(TK_EOF, EV_OPEN, 8'd0);
        clear_scan();
    endfunction

    // one value character, value closes at its limit
    function automatic void value_byte(input logic [7:0] c);
        if (attr_reported) note_event(TK_AVALUE, EV_CHAR, c);
        run_len = run_len + 8'd1;
        if (run_len >= floor_one({1'b0, value_max})) begin
            if (attr_reported) note_event(TK_AVALUE, EV_CLOSE, 8'd0);
            mode = M_ATTR_WS;
        end
    endfunction

    function automatic void scan_byte(input logic [7:0] c);
        logic        again;
        token_kind_t kind;
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            case (mode)
                M_TEXT: begin
                    if (c == CH_LT) begin
                        note_event(TK_TEXT, EV_CLOSE, 8'd0);
                        mode = M_TAG_OPEN;
                    end else begin
                        note_event(TK_TEXT, EV_CHAR, c);
                        run_len = run_len + 8'd1;
                        if (run_len >= floor_one(text_max)) begin
                            note_event(TK_TEXT, EV_CLOSE, 8'd0);
                            mode = M_DATA;
                        end
                    end
                end
                M_TAG_OPEN: begin
                    run_len = 8'd0;
                    if (c == CH_SLASH) begin
                        note_event(TK_END, EV_OPEN, 8'd0);
                        mode = M_END_NAME;
                    end else begin
                        note_event(TK_START, EV_OPEN, 8'd0);
                        attrs_taken = 4'd0;
                        if (name_byte(c)) begin
                            note_event(TK_START, EV_CHAR, fold_case(c));
                            run_len = 8'd1;
                            if (run_len >= name_cap()) begin
                                note_event(TK_START, EV_CLOSE, 8'd0);
                                mode = M_ATTR_WS;
                            end else begin
                                mode = M_START_NAME;
                            end
                        end else begin
                            // empty tag name, byte is looked at again
                            note_event(TK_START, EV_CLOSE, 8'd0);
                            mode  = M_ATTR_WS;
                            again = 1'b1;
                        end
                    end
                end
                M_START_NAME, M_END_NAME: begin
                    if (mode == M_START_NAME) kind = TK_START;
                    else kind = TK_END;
                    if (name_byte(c)) begin
                        note_event(kind, EV_CHAR, fold_case(c));
                        run_len = run_len + 8'd1;
                        if (run_len >= name_cap()) begin
                            note_event(kind, EV_CLOSE, 8'd0);
                            if (kind == TK_START) mode = M_ATTR_WS;
                            else mode = M_END_SKIP;
                        end
                    end else begin
                        note_event(kind, EV_CLOSE, 8'd0);
                        if (kind == TK_START) begin
                            mode  = M_ATTR_WS;
                            again = 1'b1;
                        end else if (c == CH_GT) begin
                            mode = M_DATA;
                        end else begin
                            mode = M_END_SKIP;
                        end
                    end
                end
                M_END_SKIP: begin
                    if (c == CH_GT) mode = M_DATA;
                end
                M_ATTR_WS: begin
                    if (c == CH_GT) begin
                        mode = M_DATA;
                    end else if (name_byte(c)) begin
                        attr_reported = (attrs_taken < attr_max);
                        if (attr_reported) begin
                            attrs_taken = attrs_taken + 4'd1;
                            note_event(TK_ANAME, EV_OPEN, 8'd0);
                            note_event(TK_ANAME, EV_CHAR, fold_case(c));
                        end
                        run_len = 8'd1;
                        if (run_len >= name_cap()) begin
                            if (attr_reported) note_event(TK_ANAME, EV_CLOSE, 8'd0);
                            mode = M_AFTER_NAME;
                        end else begin
                            mode = M_ATTR_NAME;
                        end
                    end
                end
                M_ATTR_NAME: begin
                    if (name_byte(c)) begin
                        if (attr_reported) note_event(TK_ANAME, EV_CHAR, fold_case(c));
                        run_len = run_len + 8'd1;
                        if (run_len >= name_cap()) begin
                            if (attr_reported) note_event(TK_ANAME, EV_CLOSE, 8'd0);
                            mode = M_AFTER_NAME;
                        end
                    end else begin
                        if (attr_reported) note_event(TK_ANAME, EV_CLOSE, 8'd0);
                        mode  = M_AFTER_NAME;
                        again = 1'b1;
                    end
                end
                M_AFTER_NAME: begin
                    if (c == CH_EQ) begin
                        mode = M_BEFORE_VALUE;
                    end else if (!blank_byte(c)) begin
                        mode  = M_ATTR_WS;
                        again = 1'b1;
                    end
                end
                M_BEFORE_VALUE: begin
                    if (!blank_byte(c)) begin
                        run_len = 8'd0;
                        if (attr_reported) note_event(TK_AVALUE, EV_OPEN, 8'd0);
                        if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                            quote_single = (c == CH_SQUOTE);
                            mode         = M_QUOTED;
                        end else if (c == CH_GT) begin
                            if (attr_reported) note_event(TK_AVALUE, EV_CLOSE, 8'd0);
                            mode = M_DATA;
                        end else begin
                            mode = M_UNQUOTED;
                            value_byte(c);
                        end
                    end
                end
                M_QUOTED: begin
                    if (c == (quote_single ? CH_SQUOTE : CH_DQUOTE)) begin
                        if (attr_reported) note_event(TK_AVALUE, EV_CLOSE, 8'd0);
                        mode = M_ATTR_WS;
                    end else begin
                        value_byte(c);
                    end
                end
                M_UNQUOTED: begin
                    if (blank_byte(c) || c == CH_GT) begin
                        if (attr_reported) note_event(TK_AVALUE, EV_CLOSE, 8'd0);
                        if (c == CH_GT) mode = M_DATA;
                        else mode = M_ATTR_WS;
                    end else begin
                        value_byte(c);
                    end
                end
                default: begin
                    // data mode: a byte other than '<' opens text
                    if (c == CH_LT) begin
                        mode = M_TAG_OPEN;
                    end else begin
                        note_event(TK_TEXT, EV_OPEN, 8'd0);
                        note_event(TK_TEXT, EV_CHAR, c);
                        run_len = 8'd1;
                        if (run_len >= floor_one(text_max)) begin
                            note_event(TK_TEXT, EV_CLOSE, 8'd0);
                            mode = M_DATA;
                        end else begin
                            mode = M_TEXT;
                        end
                    end
                end
            endcase
        end
    endfunction

    function automatic void predict_tokens(input logic eoi, input logic [7:0] c);
        byte_event_count = 0;
        if (eoi) finish_document();
        else scan_byte(c);
        for (int i = 0; i < byte_event_count; i++) begin
            byte_events[i].last = (i == byte_event_count - 1);
            expected_events.push_back(byte_events[i]);
        end
    endfunction

    function automatic void log_mismatch(input string what, input token_event_t want,
                                         input token_event_t seen);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s: expected kind %0d event %0d char %02h last %0d, got kind %0d event %0d char %02h last %0d",
                     $realtime, what, want.kind, want.ev, want.ch, want.last,
                     seen.kind, seen.ev, seen.ch, seen.last);
    endfunction

    always @(posedge aclk) begin
        token_event_t seen;
        token_event_t want;
        if (!aresetn) begin
            clear_scan();
            attr_max  = ATTR_LIMIT_RST;
            name_max  = NAME_LIMIT_RST;
            value_max = VALUE_LIMIT_RST;
            text_max  = TEXT_LIMIT_RST;
            expected_events.delete();
            mismatch_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                seen = '{kind: token_kind_t'(m_token_kind), ev: event_kind_t'(m_event_kind),
                         ch: m_char_out, last: m_last_of_run};
                if (expected_events.size() == 0) begin
                    log_mismatch("unexpected event", '0, seen);
                end else begin
                    want = expected_events.pop_front();
                    if (seen !== want) log_mismatch("event differs", want, seen);
                end
            end
            if (s_valid && s_ready) predict_tokens(s_end_of_input, s_in_byte);
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_ATTR_LIMIT:  attr_max  = cfg_wdata[3:0];
                    REG_NAME_LIMIT:  name_max  = cfg_wdata[4:0];
                    REG_VALUE_LIMIT: value_max = cfg_wdata[6:0];
                    REG_TEXT_LIMIT:  text_max  = cfg_wdata;
                    default: ;
                endcase
            end
        end
        events_pending = expected_events.size();
    end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: top-level testbench of the html tag tokenizer
// drives bytes and end markers over the input channel with random gaps and
// result-side stalls, walks the limit registers through several settings,
// and leaves prediction and comparison to the event checker beside the block
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import htt_pkg::*;

    // cycles without any transfer before the run is given up
    localparam int unsigned StallLimit = 2000;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte      = 8'd0;
    logic        s_end_of_input = 1'b0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [2:0]  m_token_kind;
    logic [1:0]  m_event_kind;
    logic [7:0]  m_char_out;
    logic        m_last_of_run;
    logic        cfg_we         = 1'b0;
    logic [1:0]  cfg_addr       = 2'd0;
    logic [7:0]  cfg_wdata      = 8'd0;

    int unsigned mismatch_count;
    int unsigned events_pending;
    int unsigned quiet_cycles   = 0;
    // high while neither side idles
    logic        steady         = 1'b0;
    logic [7:0]  doc_bytes[$];

    always #5ns aclk = ~aclk;

    html_tag_tokenizer_unit dut (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_in_byte, .s_end_of_input,
        .m_valid, .m_ready, .m_token_kind, .m_event_kind, .m_char_out, .m_last_of_run,
        .cfg_we, .cfg_addr, .cfg_wdata
    );

    token_event_checker event_check (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_in_byte, .s_end_of_input,
        .m_valid, .m_ready, .m_token_kind, .m_event_kind, .m_char_out, .m_last_of_run,
        .cfg_we, .cfg_addr, .cfg_wdata,
        .mismatch_count, .events_pending
    );

    // result side stalls in about a fifth of the cycles while steady is low
    always @(negedge aclk) m_ready <= steady || ($urandom_range(99) >= 21);

    // watchdog: any transfer restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one input transfer, with a random gap in front of it
    task automatic push_byte(input logic [7:0] b, input logic eoi);
        while (!steady && $urandom_range(99) < 21) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_in_byte      <= b;
        s_end_of_input <= eoi;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
    endtask

    // end marker, byte field left random
    task automatic end_document();
        push_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // stop sending, let every expected event drain, then let the block idle
    // for the given tail, for bytes that cause no event
    task automatic wait_idle(input int unsigned tail);
        s_valid <= 1'b0;
        while (events_pending != 0) @(negedge aclk);
        repeat (tail) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        @(negedge aclk);
    endtask

    task automatic set_limits(input logic [3:0] attr_lim, input logic [4:0] name_lim,
                              input logic [6:0] value_lim, input logic [7:0] text_lim);
        wait_idle(8);
        write_reg(REG_ATTR_LIMIT, {4'd0, attr_lim});
        write_reg(REG_NAME_LIMIT, {3'd0, name_lim});
        write_reg(REG_VALUE_LIMIT, {1'b0, value_lim});
        write_reg(REG_TEXT_LIMIT, text_lim);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_name_char();
        case ($urandom_range(0, 7))
            0, 1, 2: return "a" + 8'($urandom_range(0, 25));
            3, 4:    return "A" + 8'($urandom_range(0, 25));
            5:       return "0" + 8'($urandom_range(0, 9));
            6:       return CH_DASH;
            default: return $urandom_range(0, 1) ? CH_UNDER : CH_COLON;
        endcase
    endfunction

    function automatic logic [7:0] pick_blank();
        return $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13));
    endfunction

    // any byte but '<', so a text run stays one run
    function automatic logic [7:0] pick_text_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_LT);
        return c;
    endfunction

    function automatic logic [7:0] pick_value_char();
        return $urandom_range(0, 3) == 0 ? pick_text_char() : pick_name_char();
    endfunction

    // one random document: mostly well-formed tags and text, some noise,
    // sometimes cut short so the end marker lands inside a token
    task automatic build_document();
        logic [7:0] q;
        doc_bytes.delete();
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    repeat ($urandom_range(1, 6)) doc_bytes.push_back(pick_text_char());
                end
                2, 3, 4, 5: begin
                    doc_bytes.push_back(CH_LT);
                    repeat ($urandom_range(0, 5)) doc_bytes.push_back(pick_name_char());
                    repeat ($urandom_range(0, 3)) begin
                        doc_bytes.push_back(pick_blank());
                        repeat ($urandom_range(1, 4)) doc_bytes.push_back(pick_name_char());
                        case ($urandom_range(0, 5))
                            0: ;    // bare attribute
                            1: begin
                                doc_bytes.push_back(CH_EQ);
                                repeat ($urandom_range(1, 5))
                                    doc_bytes.push_back(pick_name_char());
                            end
                            2, 3: begin
                                q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                                doc_bytes.push_back(CH_EQ);
                                doc_bytes.push_back(q);
                                repeat ($urandom_range(0, 6))
                                    doc_bytes.push_back(pick_value_char());
                                doc_bytes.push_back(q);
                            end
                            4: doc_bytes.push_back(CH_EQ);
                            default: doc_bytes.push_back(CH_SLASH);
                        endcase
                    end
                    if ($urandom_range(0, 5) != 0) doc_bytes.push_back(CH_GT);
                end
                6, 7: begin
                    doc_bytes.push_back(CH_LT);
                    doc_bytes.push_back(CH_SLASH);
                    repeat ($urandom_range(1, 4)) doc_bytes.push_back(pick_name_char());
                    if ($urandom_range(0, 2) == 0) begin
                        doc_bytes.push_back(pick_blank());
                        doc_bytes.push_back(pick_value_char());
                    end
                    doc_bytes.push_back(CH_GT);
                end
                8: begin
                    repeat ($urandom_range(1, 4))
                        doc_bytes.push_back(8'($urandom_range(0, 255)));
                end
                default: begin
                    // long tag name, may cross the name limit
                    doc_bytes.push_back(CH_LT);
                    repeat ($urandom_range(20, 40)) doc_bytes.push_back(pick_name_char());
                    doc_bytes.push_back(CH_GT);
                end
            endcase
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                if (doc_bytes.size() > 1) void'(doc_bytes.pop_back());
    endtask

    task automatic run_documents(input int unsigned budget);
        int unsigned sent;
        sent = 0;
        while (sent < budget) begin
            build_document();
            // cut the document so the run keeps to its share of bytes
            while (doc_bytes.size() > 1 && sent + doc_bytes.size() + 1 > budget)
                void'(doc_bytes.pop_back());
            foreach (doc_bytes[i]) push_byte(doc_bytes[i], 1'b0);
            end_document();
            sent += doc_bytes.size() + 1;
        end
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, reset limits: text with the top byte and a zero byte,
        // start tag with quoted values, a bare attribute, junk '/', an empty value
        push_byte(8'hFF, 1'b0);
        push_byte(CH_NUL, 1'b0);
        send_string("<Ab k='x' r=\"y\" s/ t=>");
        // end tag with a tail skipped to '>'
        send_string("</P z>");
        // end marker right after a lone '<', then one in data mode
        push_byte(CH_LT, 1'b0);
        end_document();
        end_document();

        // random documents at the reset limits
        run_documents(39);

        // smallest limits: every name, value and text cut at one, no attributes
        set_limits(4'd0, 5'd1, 7'd1, 8'd1);
        run_documents(39);

        // small random limits so cuts land inside tokens
        set_limits(4'($urandom_range(1, 3)), 5'($urandom_range(2, 5)),
                   7'($urandom_range(2, 5)), 8'($urandom_range(2, 8)));
        run_documents(39);

        // zero limits behave as one
        set_limits(4'd1, 5'd0, 7'd0, 8'd0);
        run_documents(39);

        // reset limits again, the largest name, value and text limits, with neither side idling
        steady <= 1'b1;
        set_limits(4'd8, 5'd31, 7'd127, 8'd255);
        run_documents(39);

        wait_idle(20);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
